// File: rtl/i2da_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2da_pkg: shared types and constants for int32_to_decimal_ascii
// Character codes, BCD sizing and the sequencer state type.
// ----------------------------------------------------------------------------
package i2da_pkg;

   localparam int ValueWidth = 32;
   localparam int CharWidth  = 6;
   localparam int NumDigits  = 10;
   localparam int BcdWidth   = 4 * NumDigits;
   localparam int BitCntW    = $clog2(ValueWidth);
   localparam int DigCntW    = $clog2(NumDigits + 1);

   localparam logic [CharWidth-1:0] CharMinus = 6'd45;
   localparam logic [CharWidth-1:0] CharZero  = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // double-dabble correction of one BCD digit before the shift
   function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
      return (d >= 4'd5) ? 4'(d + 4'd3) : d;
   endfunction

endpackage
`default_nettype wire

// File: rtl/int32_to_decimal_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Bit-serial binary-to-BCD conversion followed by a character sequencer.
// ----------------------------------------------------------------------------
// order: after the input transfer come the double-dabble shifts, then the skip
//   check with one step per leading zero digit dropped, then the output load of
//   the first character (the minus sign for a negative value)
// flow: a new value is accepted only in idle, once the last character has been
//   loaded into the output register; output stalls hold the sequencer
// reset: synchronous, active high; clears the sequencer and the output valid
module int32_to_decimal_ascii
   import i2da_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [5:0] char_code, [7:6] zero
   output logic             rsp_tlast    // last
);

   state_type state_ff, state_in;

   logic [ValueWidth-1:0] mag_ff, mag_in;
   logic [BcdWidth-1:0]   bcd_ff, bcd_in;
   logic [BitCntW-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DigCntW-1:0]    ndig_ff, ndig_in;
   logic                  sign_ff, sign_in;

   logic                  out_valid_ff, out_valid_in;
   logic [CharWidth-1:0]  out_code_ff, out_code_in;
   logic                  out_last_ff, out_last_in;

   logic                  out_free;
   logic                  load_out;
   logic [3:0]            top_digit;
   logic [BcdWidth-1:0]   bcd_adj;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign top_digit = bcd_ff[BcdWidth-1 -: 4];

   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         bcd_adj[4*i +: 4] = bcd_adjust(bcd_ff[4*i +: 4]);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == BitCntW'(ValueWidth - 1)) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (top_digit != 4'd0 || ndig_ff == DigCntW'(1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && !sign_ff && ndig_ff == DigCntW'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      mag_in      = mag_ff;
      bcd_in      = bcd_ff;
      bit_cnt_in  = bit_cnt_ff;
      ndig_in     = ndig_ff;
      sign_in     = sign_ff;
      load_out    = 1'b0;
      out_code_in = out_code_ff;
      out_last_in = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            sign_in    = req_tdata[ValueWidth-1];
            mag_in     = req_tdata[ValueWidth-1] ? ValueWidth'(0 - req_tdata) : req_tdata;
            bcd_in     = '0;
            bit_cnt_in = '0;
            ndig_in    = DigCntW'(NumDigits);
         end
         ST_CONVERT: begin
            bcd_in     = {bcd_adj[BcdWidth-2:0], mag_ff[ValueWidth-1]};
            mag_in     = {mag_ff[ValueWidth-2:0], 1'b0};
            bit_cnt_in = BitCntW'(bit_cnt_ff + 1'b1);
         end
         ST_SKIP: begin
            // drop leading zero digits, keeping at least one
            if (top_digit == 4'd0 && ndig_ff != DigCntW'(1)) begin
               bcd_in  = {bcd_ff[BcdWidth-5:0], 4'd0};
               ndig_in = DigCntW'(ndig_ff - 1'b1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               if (sign_ff) begin
                  out_code_in = CharMinus;
                  out_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  out_code_in = CharWidth'(CharZero + {2'b00, top_digit});
                  out_last_in = (ndig_ff == DigCntW'(1));
                  bcd_in      = {bcd_ff[BcdWidth-5:0], 4'd0};
                  ndig_in     = DigCntW'(ndig_ff - 1'b1);
               end
            end
         end
         default: begin
            load_out = 1'b0;
         end
      endcase
      out_valid_in = load_out || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      ndig_ff     <= ndig_in;
      sign_ff     <= sign_in;
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_code_ff};
   assign rsp_tlast  = out_last_ff;

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_code_ff == CharMinus ||
                        (out_code_ff >= CharZero && out_code_ff <= 6'd57)))
      else $error("character code out of range");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_code_ff == CharMinus) |-> !out_last_ff)
      else $error("minus sign flagged as last");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (ndig_ff != '0 && top_digit <= 4'd9))
      else $error("emit with no digit or bad bcd digit");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CONVERT && bit_cnt_ff == '0))
      else $error("conversion did not start after input transfer");

endmodule
`default_nettype wire
